// File: rtl/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg: shared types and constants for the decimal text converter
// Holds the ASCII codes, the character type and the control bundle that
// drives the BCD shift register.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam int CHAR_BITS = 6;

    typedef logic [CHAR_BITS-1:0] t_char;

    localparam t_char ASCII_ZERO  = 6'd48;
    localparam t_char ASCII_MINUS = 6'd45;
    localparam t_char ASCII_NINE  = 6'd57;

    // Control from the sequencer to the BCD register
    typedef struct packed {
        logic clear;        // zero all digits
        logic dabble;       // adjust digits, shift one binary bit in
        logic bit_in;       // binary bit entering at the bottom
        logic shift_digit;  // drop the top digit, move the rest up
    } t_bcd_ctl;

    function automatic t_char digit_to_ascii(input logic [3:0] digit);
        digit_to_ascii = ASCII_ZERO + t_char'(digit);
    endfunction

endpackage

// File: rtl/sbda_bcd_shift.sv
// ----------------------------------------------------------------------------
// sbda_bcd_shift: BCD shift register with add-three correction
// Builds the decimal digits one binary bit per cycle, then hands them out
// one digit per cycle while shift_digit is set, most significant first.
// ----------------------------------------------------------------------------
module sbda_bcd_shift #(
    parameter int NUM_DIGITS = 10
) (
    input  logic              i_clk,
    input  sbda_pkg::t_bcd_ctl i_ctl,
    output logic [3:0]        o_top_digit
);

    localparam int BCD_BITS = 4 * NUM_DIGITS;

    logic [BCD_BITS-1:0] r_bcd;
    logic [BCD_BITS-1:0] n_adj;

    // Add three to every digit of five or more ahead of the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                n_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_bcd <= '0;
        end else if (i_ctl.dabble) begin
            r_bcd <= {n_adj[BCD_BITS-2:0], i_ctl.bit_in};
        end else if (i_ctl.shift_digit) begin
            r_bcd <= {r_bcd[BCD_BITS-5:0], 4'd0};
        end
    end

    assign o_top_digit = r_bcd[BCD_BITS-1 -: 4];

endmodule

// File: rtl/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii: signed integer to decimal ASCII text
// Converts one two's complement value into its decimal characters, most
// significant first, with a leading minus for negatives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_value. A transfer happens at a
//   rising edge with i_valid high and o_stall low. o_stall stays high from
//   the cycle after a transfer until the last character of that value has
//   been loaded into the output register.
//   Output channel: o_valid / i_stall with o_char_code and o_last. Each
//   transfer moves one character; o_last marks the final one of a number.
//   Sequence: after the input transfer the magnitude is shifted into a BCD
//   register one bit per cycle (the double-dabble loop). Then come the
//   character slots in order: the sign if negative, then each of the
//   NUM_DIGITS digit positions, leading zeros included (they are dropped,
//   not sent).
//   Stall: a held output register freezes the emit sequence; the last
//   character may still wait in the output register while the next value
//   is already being taken in.
//   Reset: synchronous active low; returns to idle with the output empty.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [5:0]                   o_char_code,
    output logic                         o_last
);

    // Digits of 2^(VALUE_BITS-1): floor((n-1)*log10(2)) + 1
    localparam int NUM_DIGITS = (((VALUE_BITS - 1) * 1233) >> 12) + 1;
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int DIG_W      = $clog2(NUM_DIGITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                  r_state;
    logic [VALUE_BITS-1:0]   r_mag;
    logic [BIT_W-1:0]        r_bit_cnt;
    logic [DIG_W-1:0]        r_dig_left;
    logic                    r_sign_pending;
    logic                    r_seen_nonzero;
    logic                    r_out_valid;
    sbda_pkg::t_char         r_out_char;
    logic                    r_out_last;

    logic                    accept;
    logic                    slot_free;
    logic                    last_digit;
    logic                    load_char;
    logic [3:0]              top_digit;
    logic [VALUE_BITS-1:0]   n_mag;
    sbda_pkg::t_bcd_ctl      bcd_ctl;

    assign accept     = i_valid && (r_state == S_IDLE);
    assign slot_free  = !r_out_valid || !i_stall;
    assign last_digit = (r_dig_left == DIG_W'(1));

    // A character goes into the output register in this slot: the sign, or a
    // digit past the leading zeros, or the units digit
    assign load_char = (r_state == S_EMIT) && slot_free &&
                       (r_sign_pending || top_digit != 4'd0 || r_seen_nonzero ||
                        last_digit);

    // Unsigned magnitude, so the most negative value cannot overflow
    assign n_mag = i_value[VALUE_BITS-1] ? VALUE_BITS'(~i_value + 1'b1)
                                         : VALUE_BITS'(i_value);

    always_comb begin
        bcd_ctl.clear       = accept;
        bcd_ctl.dabble      = (r_state == S_CONV);
        bcd_ctl.bit_in      = r_mag[VALUE_BITS-1];
        bcd_ctl.shift_digit = (r_state == S_EMIT) && slot_free && !r_sign_pending;
    end

    sbda_bcd_shift #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_bcd (
        .i_clk      (i_clk),
        .i_ctl      (bcd_ctl),
        .o_top_digit(top_digit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_sign_pending <= 1'b0;
            r_seen_nonzero <= 1'b0;
            r_bit_cnt      <= '0;
            r_dig_left     <= '0;
        end else begin
            // Fill the output register when a character is ready; otherwise
            // drop the held character once the receiver takes it
            if (load_char) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mag          <= n_mag;
                        r_sign_pending <= i_value[VALUE_BITS-1];
                        r_seen_nonzero <= 1'b0;
                        r_bit_cnt      <= BIT_W'(VALUE_BITS - 1);
                        r_dig_left     <= DIG_W'(NUM_DIGITS);
                        r_state        <= S_CONV;
                    end
                end
                S_CONV: begin
                    // Advance one magnitude bit into the BCD register
                    r_mag <= {r_mag[VALUE_BITS-2:0], 1'b0};
                    if (r_bit_cnt == '0) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_bit_cnt <= r_bit_cnt - 1'b1;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        if (r_sign_pending) begin
                            r_sign_pending <= 1'b0;
                            r_out_char     <= sbda_pkg::ASCII_MINUS;
                            r_out_last     <= 1'b0;
                        end else begin
                            // Skip leading zeros, but always keep the units digit
                            if (top_digit != 4'd0 || r_seen_nonzero || last_digit) begin
                                r_seen_nonzero <= 1'b1;
                                r_out_char     <= sbda_pkg::digit_to_ascii(top_digit);
                                r_out_last     <= last_digit;
                            end
                            r_dig_left <= r_dig_left - 1'b1;
                            if (last_digit) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_last      = r_out_last;

    // A minus sign never ends a number's text
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_char_code == sbda_pkg::ASCII_MINUS) |-> !o_last)
        else $error("minus sign flagged as last character");

    // Only a minus sign or a decimal digit ever leaves the block
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == sbda_pkg::ASCII_MINUS ||
                     (o_char_code >= sbda_pkg::ASCII_ZERO &&
                      o_char_code <= sbda_pkg::ASCII_NINE)))
        else $error("character code outside minus and digits");

    // A transfer in starts the conversion, so input is held off next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not held off after transfer");

    // The last character is loaded only as the sequencer returns to idle
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && o_last) |-> !o_stall)
        else $error("last character loaded while conversion still busy");

endmodule

// File: sim/signed_binary_to_decimal_ascii_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_test: converter check against a predictor
// Feeds signed values through the input channel in random bursts and checks
// every character on the output channel, including the last flag. The
// receiver stalls on its own pattern and holds off once for a long stretch
// so that the block fills and pushes back.
// ----------------------------------------------------------------------------

// Predicts the character stream for each accepted value and checks the
// characters as they come out, oldest first.
class decimal_text_scoreboard #(int BITS = 32);

    localparam int MAX_DIGITS = 20;

    typedef struct packed {
        sbda_pkg::t_char code;
        logic            last;
    } t_text_char;

    t_text_char pending_chars[$];
    int         failures;

    function new();
        failures = 0;
    endfunction

    // Work out the decimal text of one value and queue its characters.
    function void note_value(logic signed [BITS-1:0] value);
        logic [BITS-1:0] magnitude;
        logic [3:0]      digit_buf[MAX_DIGITS];
        int              num_digits;
        t_text_char      ch;
        magnitude  = value[BITS-1] ? (~value + 1'b1) : value;
        num_digits = 0;
        if (magnitude == 0) begin
            digit_buf[0] = 4'd0;
            num_digits   = 1;
        end
        while (magnitude != 0) begin
            digit_buf[num_digits] = 4'(magnitude % 10);
            magnitude             = magnitude / 10;
            num_digits++;
        end
        if (value[BITS-1]) begin
            ch.code = sbda_pkg::ASCII_MINUS;
            ch.last = 1'b0;
            pending_chars.push_back(ch);
        end
        for (int k = num_digits - 1; k >= 0; k--) begin
            ch.code = sbda_pkg::ASCII_ZERO + sbda_pkg::t_char'(digit_buf[k]);
            ch.last = (k == 0);
            pending_chars.push_back(ch);
        end
    endfunction

    function void check_char(sbda_pkg::t_char code, logic last);
        t_text_char want;
        if (pending_chars.size() == 0) begin
            $error("unexpected character: char_code %0d last %0b", code, last);
            failures++;
            return;
        end
        want = pending_chars.pop_front();
        if (code !== want.code) begin
            $error("char_code mismatch: expected %0d, actual %0d", want.code, code);
            failures++;
        end
        if (last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, last);
            failures++;
        end
    endfunction

    function int outstanding();
        return pending_chars.size();
    endfunction

endclass

module signed_binary_to_decimal_ascii_test;

    localparam int VALUE_BITS    = 32;
    localparam int RANDOM_ITEMS  = 136;
    // The cycle limit covers the worst case per item even with every
    // character stalled, plus the long hold-off once.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_OFF_AT   = 2500;
    localparam int HOLD_OFF_LEN  = 600;
    localparam int DRAIN_CYCLES  = VALUE_BITS + 30;

    typedef enum {
        RX_FREE,
        RX_CHOPPY,
        RX_LIGHT,
        RX_SLOW,
        RX_HOLD
    } t_rx_mode;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic signed [VALUE_BITS-1:0] i_value;
    logic                         o_valid;
    logic                         i_stall;
    logic [5:0]                   o_char_code;
    logic                         o_last;

    decimal_text_scoreboard #(VALUE_BITS) text_sb;

    int cycle_count = 0;
    int burst_left;

    signed_binary_to_decimal_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("signed_binary_to_decimal_ascii_test failed");
            $finish;
        end
    end

    // Offer one value and hold it until the block takes it. The value is
    // noted for prediction at the edge of the transfer.
    task automatic send_value(input logic signed [VALUE_BITS-1:0] value);
        i_valid <= 1'b1;
        i_value <= value;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        text_sb.note_value(value);
    endtask

    // Drop valid for a number of cycles; scramble the idle payload too.
    task automatic idle_sender(input int cycles);
        i_valid <= 1'b0;
        i_value <= $urandom();
        repeat (cycles) @(posedge i_clk);
    endtask

    // Sender pacing: bursts of random length, random gaps between them.
    // Gaps span short and long so they land on every phase of a conversion.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 5);
            end else begin
                gap = $urandom_range(1, 70);
            end
            idle_sender(gap);
        end
    endtask

    // Random value: mostly shaped around digit-count boundaries and small
    // numbers, the rest full-width noise so every input bit toggles.
    function automatic logic signed [VALUE_BITS-1:0] pick_value();
        logic signed [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0]        pow10;
        int                           exponent;
        case ($urandom_range(0, 9)) inside
            [0:3]: begin
                v = $urandom();
            end
            [4:5]: begin
                v = $urandom_range(0, 99);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            [6:7]: begin
                // Next to a power of ten, where the digit count changes
                exponent = $urandom_range(0, 9);
                pow10    = 1;
                repeat (exponent) pow10 = pow10 * 10;
                v = pow10 + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            8: begin
                v = $urandom_range(0, 999999);
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            default: begin
                // Near the two ends of the range
                v = {1'b0, {(VALUE_BITS-1){1'b1}}} - $urandom_range(0, 3);
                if ($urandom_range(0, 1) == 1) v = ~v;
            end
        endcase
        return v;
    endfunction

    // Receiver: stall on a pattern of segments, check each transfer.
    // Hold off once for a long stretch while the sender keeps offering,
    // so the output register fills and the input gets stalled.
    initial begin
        t_rx_mode rx_mode;
        int       seg_left;
        int       rx_cycles;
        bit       held_off;
        i_stall   = 1'b0;
        rx_mode   = RX_FREE;
        seg_left  = 0;
        rx_cycles = 0;
        held_off  = 1'b0;
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (i_rst_n && o_valid && !i_stall) begin
                text_sb.check_char(sbda_pkg::t_char'(o_char_code), o_last);
            end
            if (seg_left == 0) begin
                if (!held_off && rx_cycles >= HOLD_OFF_AT) begin
                    rx_mode  = RX_HOLD;
                    seg_left = HOLD_OFF_LEN;
                    held_off = 1'b1;
                end else begin
                    case ($urandom_range(0, 3))
                        0:       rx_mode = RX_FREE;
                        1:       rx_mode = RX_CHOPPY;
                        2:       rx_mode = RX_LIGHT;
                        default: rx_mode = RX_SLOW;
                    endcase
                    seg_left = $urandom_range(20, 200);
                end
            end
            seg_left--;
            case (rx_mode)
                RX_FREE:   i_stall <= 1'b0;
                RX_CHOPPY: i_stall <= $urandom_range(0, 1);
                RX_LIGHT:  i_stall <= ($urandom_range(0, 9) == 0);
                RX_SLOW:   i_stall <= ($urandom_range(0, 4) != 0);
                default:   i_stall <= 1'b1;
            endcase
        end
    end

    // Main sequence: reset, directed values, random values, drain.
    initial begin
        logic signed [VALUE_BITS-1:0] directed[$];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_value = '0;
        text_sb = new();
        directed = '{
            0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
            7, 123456789, -987654321,
            999999999, 1000000000, -1000000000, -999999999,
            2147483647, -2147483647, 32'sh8000_0000,
            1073741824, -1073741824, 32'sh5555_5555, 32'shAAAA_AAAA
        };
        burst_left = 0;

        // Hold reset, then release it.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_value(directed[i]);
            pace_sender();
        end

        repeat (RANDOM_ITEMS) begin
            send_value(pick_value());
            pace_sender();
        end
        i_valid <= 1'b0;

        // Wait for every predicted character, then watch a while longer
        // for anything stray.
        while (text_sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (text_sb.failures == 0) begin
            $display("signed_binary_to_decimal_ascii_test passed");
        end else begin
            $display("signed_binary_to_decimal_ascii_test failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/sbda_pkg.sv
rtl/sbda_bcd_shift.sv
rtl/signed_binary_to_decimal_ascii.sv
sim/signed_binary_to_decimal_ascii_test.sv
